>>> hw/rtl/aisp_pkg.sv
// Package for the AIVDM sentence field parser: result record, status and kind codes,
// prefix table, field limits and a saturating decimal accumulator step.
// No dependencies.
package aisp_pkg;

	// Field split limits
	localparam int unsigned MAX_FIELDS = 10;
	localparam int unsigned MIN_FIELDS = 7;
	localparam int unsigned PREFIX_LEN = 6;
	localparam int unsigned FIELD_W    = 4;   // holds a field index up to fifteen

	// Field numbers of interest
	localparam logic [FIELD_W-1:0] FLD_TOTAL   = 4'd1;
	localparam logic [FIELD_W-1:0] FLD_SEQ     = 4'd2;
	localparam logic [FIELD_W-1:0] FLD_MSG_ID  = 4'd3;
	localparam logic [FIELD_W-1:0] FLD_CHANNEL = 4'd4;
	localparam logic [FIELD_W-1:0] FLD_PAYLOAD = 4'd5;
	localparam logic [FIELD_W-1:0] FLD_FILL    = 4'd6;

	// Separator and digit characters
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Summary status
	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_PREFIX = 2'd1,
		STATUS_FEW_FIELDS = 2'd2
	} status_t;

	// One result beat
	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_char;
		logic [7:0]  total_parts;
		logic [7:0]  sequence_number;
		logic [63:0] message_id_chars;
		logic [3:0]  message_id_length;
		logic [7:0]  radio_channel;
		logic [7:0]  fill_bit_count;
		status_t     status;
		logic        last_of_run;
	} result_t;

	// Expected sentence prefix "!AIVDM"
	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h21; // '!'
			3'd1:    ch = 8'h41; // 'A'
			3'd2:    ch = 8'h49; // 'I'
			3'd3:    ch = 8'h56; // 'V'
			3'd4:    ch = 8'h44; // 'D'
			3'd5:    ch = 8'h4D; // 'M'
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// One step of a saturating decimal accumulator
	function automatic logic [7:0] dec_step(input logic [7:0] acc, input logic [7:0] ch);
		logic [11:0] sum;
		sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, ch[3:0]};
		return (sum > 12'd255) ? 8'hFF : sum[7:0];
	endfunction

endpackage

>>> hw/rtl/aisp_result_fifo.sv
// Four-entry result queue for the AIVDM parser: takes up to two result beats a cycle,
// hands out one beat a cycle on the master side while out_ready is high. Depends on aisp_pkg.
module aisp_result_fifo
	import aisp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  result_t    push0,
	input  result_t    push1,
	output logic       room2,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_data
);

	localparam int unsigned DEPTH = 4;

	result_t    mem [DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] wr_ptr_nx;

	assign pop       = out_valid & out_ready;
	assign out_valid = (count_q != 3'd0);
	assign out_data  = mem[rd_ptr_q];
	assign room2     = (count_q <= 3'd2);
	assign wr_ptr_nx = wr_ptr_q + 2'd1;

	// Storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_ptr_nx] <= push1;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push_cnt} - {2'b00, pop};
		end
	end

endmodule

>>> hw/rtl/aivdm_sentence_field_parser_core.sv
// AIVDM sentence field parser, top level: byte-wise field split and result assembly.
// Depends on aisp_pkg and aisp_result_fifo.
//
// Takes one sentence byte per cycle on the slave stream (tlast on the final byte) and
// returns results on the master stream: tuser 0 is a payload character of field 5,
// tuser 1 is the sentence summary, which also carries tlast. Each byte updates the
// parse registers in the cycle it is taken; its results enter a four-entry queue, so
// the slave side keeps one byte per cycle while the master side takes one beat per
// cycle. Only a last byte that falls in the payload field gives two beats. With the
// master side always ready the queue never holds more than two beats; tready falls
// only while master back-pressure leaves three or more beats waiting, and rises again
// once they drain. There is no start-up sweep: the block is ready straight out of reset.
module aivdm_sentence_field_parser_core
	import aisp_pkg::*;
#(
	parameter int unsigned MAX_SENTENCE_BYTES = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] byte_in
	input  logic         s_tlast,  // end_of_sentence
	// master stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,  // payload_char, total_parts, sequence_number,
	                               // message_id_chars, message_id_length,
	                               // radio_channel, fill_bit_count, status, 2'b0
	output logic         m_tuser,  // kind
	output logic         m_tlast   // last_of_run
);

	localparam int unsigned POS_W = $clog2(MAX_SENTENCE_BYTES);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_SENTENCE_BYTES - 1);

	// Parse state
	logic [POS_W-1:0]   pos_q;
	logic [FIELD_W-1:0] field_q;
	logic               prefix_good_q;
	logic               leading_q;
	logic [7:0]         total_q;
	logic [7:0]         seq_q;
	logic [63:0]        msg_id_q;
	logic [3:0]         msg_cnt_q;
	logic [7:0]         chan_q;
	logic               chan_taken_q;
	logic [7:0]         fill_q;

	logic [POS_W-1:0]   pos_d;
	logic [FIELD_W-1:0] field_d;
	logic               prefix_good_d;
	logic               leading_d;
	logic [7:0]         total_d;
	logic [7:0]         seq_d;
	logic [63:0]        msg_id_d;
	logic [3:0]         msg_cnt_d;
	logic [7:0]         chan_d;
	logic               chan_taken_d;
	logic [7:0]         fill_d;

	logic               accept;
	logic               pay_en;
	logic               is_digit;
	logic               room2;
	logic [1:0]         push_cnt;
	result_t            pay_res;
	result_t            sum_res;
	result_t            push0;
	result_t            out_res;
	status_t            st;

	assign accept   = s_tvalid & s_tready;
	assign s_tready = room2;
	assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);

	// Next parse state for the incoming byte
	always_comb begin
		pos_d         = pos_q;
		field_d       = field_q;
		prefix_good_d = prefix_good_q;
		leading_d     = leading_q;
		total_d       = total_q;
		seq_d         = seq_q;
		msg_id_d      = msg_id_q;
		msg_cnt_d     = msg_cnt_q;
		chan_d        = chan_q;
		chan_taken_d  = chan_taken_q;
		fill_d        = fill_q;
		pay_en        = 1'b0;
		if (pos_q < POS_LIMIT) begin
			if (pos_q < POS_W'(PREFIX_LEN) && s_tdata != prefix_char(pos_q[2:0])) begin
				prefix_good_d = 1'b0;
			end
			pos_d = pos_q + POS_W'(1);
			if (s_tdata == CH_COMMA || s_tdata == CH_STAR) begin
				if (field_q < FIELD_W'(MAX_FIELDS)) begin
					field_d = field_q + FIELD_W'(1);
				end
				leading_d = 1'b1;
			end else begin
				case (field_q)
					FLD_TOTAL, FLD_SEQ, FLD_FILL: begin
						if (leading_q) begin
							if (!is_digit) begin
								leading_d = 1'b0;
							end else if (field_q == FLD_TOTAL) begin
								total_d = dec_step(total_q, s_tdata);
							end else if (field_q == FLD_SEQ) begin
								seq_d = dec_step(seq_q, s_tdata);
							end else begin
								fill_d = dec_step(fill_q, s_tdata);
							end
						end
					end
					FLD_MSG_ID: begin
						if (msg_cnt_q < 4'd8) begin
							msg_id_d[msg_cnt_q[2:0]*8 +: 8] = s_tdata;
						end
						if (msg_cnt_q < 4'd9) begin
							msg_cnt_d = msg_cnt_q + 4'd1;
						end
					end
					FLD_CHANNEL: begin
						if (!chan_taken_q) begin
							chan_d       = s_tdata;
							chan_taken_d = 1'b1;
						end
					end
					FLD_PAYLOAD: begin
						pay_en = prefix_good_d;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result beats for this byte
	always_comb begin
		if (!prefix_good_d || pos_d < POS_W'(PREFIX_LEN)) begin
			st = STATUS_BAD_PREFIX;
		end else if (field_d < FIELD_W'(MIN_FIELDS - 1)) begin
			st = STATUS_FEW_FIELDS;
		end else begin
			st = STATUS_OK;
		end

		pay_res              = '0;
		pay_res.kind         = KIND_PAYLOAD;
		pay_res.payload_char = s_tdata;
		pay_res.status       = STATUS_OK;

		sum_res             = '0;
		sum_res.kind        = KIND_SUMMARY;
		sum_res.status      = st;
		sum_res.last_of_run = 1'b1;
		if (st == STATUS_OK) begin
			sum_res.total_parts     = total_d;
			sum_res.sequence_number = seq_d;
			if (msg_cnt_d <= 4'd8) begin
				sum_res.message_id_chars  = msg_id_d;
				sum_res.message_id_length = msg_cnt_d;
			end
			sum_res.radio_channel  = chan_d;
			sum_res.fill_bit_count = fill_d;
		end

		push0    = pay_en ? pay_res : sum_res;
		push_cnt = accept ? ({1'b0, pay_en} + {1'b0, s_tlast}) : 2'd0;
	end

	// Parse registers; a last byte returns them to the start-of-sentence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			field_q       <= '0;
			prefix_good_q <= 1'b1;
			leading_q     <= 1'b1;
			total_q       <= '0;
			seq_q         <= '0;
			msg_id_q      <= '0;
			msg_cnt_q     <= '0;
			chan_q        <= '0;
			chan_taken_q  <= 1'b0;
			fill_q        <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				pos_q         <= '0;
				field_q       <= '0;
				prefix_good_q <= 1'b1;
				leading_q     <= 1'b1;
				total_q       <= '0;
				seq_q         <= '0;
				msg_id_q      <= '0;
				msg_cnt_q     <= '0;
				chan_q        <= '0;
				chan_taken_q  <= 1'b0;
				fill_q        <= '0;
			end else begin
				pos_q         <= pos_d;
				field_q       <= field_d;
				prefix_good_q <= prefix_good_d;
				leading_q     <= leading_d;
				total_q       <= total_d;
				seq_q         <= seq_d;
				msg_id_q      <= msg_id_d;
				msg_cnt_q     <= msg_cnt_d;
				chan_q        <= chan_d;
				chan_taken_q  <= chan_taken_d;
				fill_q        <= fill_d;
			end
		end
	end

	// Result queue
	aisp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (push0),
		.push1     (sum_res),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// Master beat packing
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last_of_run;
	assign m_tdata = {2'b00, out_res.status, out_res.fill_bit_count, out_res.radio_channel,
	                  out_res.message_id_length, out_res.message_id_chars,
	                  out_res.sequence_number, out_res.total_parts, out_res.payload_char};

endmodule
